/* rtl/itora_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itora_pkg
// types and constants shared by the integer to ascii converter
// ----------------------------------------------------------------------------
package itora_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] SIGNED_RADIX = 6'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX    = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX    = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  // digit value to ascii, digits from ten up map to lowercase letters
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DECIMAL_DIGITS) begin
      r = CHAR_ZERO + CHAR_W'(d);
    end else begin
      r = CHAR_LOWER_A + CHAR_W'(d - DECIMAL_DIGITS);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/itora_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itora_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module itora_div #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          cont,
  input  wire logic [VALUE_BITS-1:0]         dividend,
  input  wire logic [itora_pkg::RADIX_W-1:0] radix,
  output logic                               done,
  output logic [VALUE_BITS-1:0]              quotient,
  output logic [itora_pkg::DIGIT_W-1:0]      remainder
);
  import itora_pkg::*;

  localparam int BCNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] sh;
  logic [DIGIT_W-1:0]    rem;
  logic [RADIX_W-1:0]    divisor;
  logic [BCNT_W-1:0]     bcnt;
  logic                  busy;

  logic [DIGIT_W:0]   rem_sh;
  logic               ge;
  logic [DIGIT_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, sh[VALUE_BITS-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bcnt == BCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // a continued pass divides the quotient left from the last one
      if (!cont) begin
        sh      <= dividend;
        divisor <= radix;
      end
      rem  <= '0;
      bcnt <= BCNT_W'(VALUE_BITS);
    end else if (busy) begin
      sh   <= {sh[VALUE_BITS-2:0], ge};
      rem  <= ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      bcnt <= bcnt - 1'b1;
    end
  end

  assign quotient  = sh;
  assign remainder = rem;

endmodule
`default_nettype wire

/* rtl/itora_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itora_store
// digit memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module itora_store #(
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(MAX_DIGITS)-1:0]     waddr,
  input  wire logic [itora_pkg::DIGIT_W-1:0]     wdata,
  input  wire logic [$clog2(MAX_DIGITS)-1:0]     raddr,
  output logic [itora_pkg::DIGIT_W-1:0]          rdata
);
  import itora_pkg::*;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/integer_to_radix_ascii.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// converts an integer to its ascii digits in a radix from 2 to 36, or to
// signed decimal, one character per output item, most significant first
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    in_data  : req_type, value, radix
//  out      out_valid / out_ready  out_data : character, last
//
//  each digit is one pass of the bit-serial divider, whose remainder is
//  written to the digit memory; in_ready stays low until the last
//  character of an item has entered the output register
//  characters leave through a single output register, digits via S_READ
//  a stalled out_ready holds the emitter, the divider never waits on it
//  synchronous active-high reset idles the control, the digit memory is
//  not cleared since every digit is written before it is read
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire itora_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output itora_pkg::out_t     out_data
);
  import itora_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_READ = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic             neg, neg_next;

  // input decode: value trimmed or zero-extended to VALUE_BITS
  logic [VALUE_BITS+VALUE_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]         value_v;
  logic [VALUE_BITS-1:0]         mag;
  logic                          in_neg;
  logic [RADIX_W-1:0]            radix_sel;

  // divider and digit memory hookup
  logic                  div_start, div_cont, div_done;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_W-1:0]    rem;
  logic                  st_we;
  logic [CNT_W-1:0]      count_m1, count_p1;
  logic [DIGIT_W-1:0]    rd_digit;

  logic accept, out_free, last_digit_done;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    value_ext = {{VALUE_BITS{1'b0}}, in_data.value};
    value_v   = value_ext[VALUE_BITS-1:0];
    in_neg    = in_data.req_type && value_v[VALUE_BITS-1];
    // two's complement magnitude, also right for the most negative value
    mag       = in_neg ? (~value_v + VALUE_BITS'(1)) : value_v;

    if (in_data.req_type) begin
      radix_sel = SIGNED_RADIX;
    end else if (in_data.radix inside {[MIN_RADIX:MAX_RADIX]}) begin
      radix_sel = in_data.radix;
    end else if (in_data.radix < MIN_RADIX) begin
      radix_sel = MIN_RADIX;
    end else begin
      radix_sel = MAX_RADIX;
    end
  end

  assign count_m1 = count - 1'b1;
  assign count_p1 = count + 1'b1;

  // conversion finishes when the quotient runs out or the store is full
  assign last_digit_done = (quot == '0) || (count_p1 == CNT_W'(MAX_DIGITS));

  always_comb begin
    state_next = state;
    count_next = count;
    neg_next   = neg;
    div_start  = 1'b0;
    div_cont   = 1'b0;
    st_we      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          div_start  = 1'b1;
          count_next = '0;
          neg_next   = in_neg;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_we      = 1'b1;
          count_next = count_p1;
          if (last_digit_done) begin
            state_next = neg ? S_SIGN : S_READ;
          end else begin
            div_start = 1'b1;
            div_cont  = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        // memory read of the top digit is in flight
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          count_next = count_m1;
          state_next = (count == CNT_W'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      neg   <= neg_next;
    end
  end

  itora_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .cont     (div_cont),
    .dividend (mag),
    .radix    (radix_sel),
    .done     (div_done),
    .quotient (quot),
    .remainder(rem)
  );

  // digits stored least significant first, read back from the top
  itora_store #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(rem),
    .raddr(count_m1[ADDR_W-1:0]),
    .rdata(rd_digit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_SIGN || state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SIGN && out_free) begin
      out_data.character <= CHAR_MINUS;
      out_data.last      <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_data.character <= digit_char(rd_digit);
      out_data.last      <= (count == CNT_W'(1));
    end
  end

endmodule
`default_nettype wire
